FILE: design/lcst_pkg.sv
// ----------------------------------------------------------------------------
// Least-connections server table package
// Command and status codes, the heartbeat reset value and the entry type
// shared by the server table design.
`default_nettype none

package lcst_pkg;

    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_REMOVE     = 3'd1;
    localparam logic [2:0] CMD_QUERY      = 3'd2;
    localparam logic [2:0] CMD_PICK       = 3'd3;
    localparam logic [2:0] CMD_DISCONNECT = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [7:0] HEARTBEAT_RESET = 8'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] ip;
        logic [47:0] ports;
        logic [15:0] clients;
        logic [7:0]  heartbeat;
    } entry_t;

endpackage

`default_nettype wire

FILE: design/least_connections_server_table_core.sv
// ----------------------------------------------------------------------------
// Least-connections server table
// Table of servers in insertion order with a sequential scan engine.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. The engine then
// walks the table through a single read port of the entry memory and a single
// write port, reading each entry in S_READ and evaluating it in S_EVAL.
// After the scan come the write-back state S_WRITE and the state S_DONE, in
// which the selected entry has been fetched, and the result beat follows in
// the next cycle. Lookups by id or IP stop at the first match; pick, remove
// and tick walk every entry, and remove and tick rewrite later entries in
// place to compact the table. Busy is high until the result beat, and a new
// command may be taken in the cycle of that beat. The result beat appears for
// one cycle with done high; the receiver cannot stall it. initial_heartbeat is
// written over the APB-style port at address 0 and reads back there. Reset
// empties the table, clears the id counter and sets initial_heartbeat to 3;
// the entry memory itself is not cleared since only entries below the count
// are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module least_connections_server_table_core
    import lcst_pkg::*;
#(
    parameter int MAX_SERVERS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] server_ip,
    input  wire logic [15:0] lookup_id,
    input  wire logic [15:0] data_port,
    input  wire logic [15:0] command_port,
    input  wire logic [15:0] retran_port,
    output logic             done,
    output logic [1:0]       status,
    output logic             found,
    output logic [15:0]      out_server_id,
    output logic [31:0]      out_server_ip,
    output logic [15:0]      out_data_port,
    output logic [15:0]      out_command_port,
    output logic [15:0]      out_retran_port,
    output logic [15:0]      out_clients,
    output logic             table_empty
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    entry_t mem [MAX_SERVERS];
    entry_t rd_reg;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic [CW-1:0] wi_reg, wi_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic          hit_ok_reg, hit_ok_next;
    logic [15:0]   best_reg, best_next;
    logic [15:0]   next_id_reg, next_id_next;
    logic [7:0]    init_hb_reg;
    logic [2:0]    cmd_reg;
    logic [31:0]   ip_reg;
    logic [15:0]   id_reg;
    logic [47:0]   ports_reg;
    logic          removing_reg, removing_next;

    logic          we;
    logic [IW-1:0] wa;
    entry_t        wd;
    logic [IW-1:0] ra;

    logic          upd_we;
    entry_t        upd_e;

    logic          out_v_reg;
    logic [1:0]    out_st_reg;
    logic          out_f_reg;
    entry_t        out_e_reg;

    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {24'd0, init_hb_reg} : 32'd0;
    assign busy   = (state_reg != S_IDLE);
    assign ra     = ri_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[ra];
        if (we)
        begin
            mem[wa] <= wd;
        end
        else if (upd_we)
        begin
            mem[hit_reg[IW-1:0]] <= upd_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg   <= cmd;
            ip_reg    <= server_ip;
            id_reg    <= lookup_id;
            ports_reg <= {data_port, command_port, retran_port};
        end
    end

    // The scan: S_READ issues a read at ri, S_EVAL looks at the entry.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ri_next       = ri_reg;
        wi_next       = wi_reg;
        hit_next      = hit_reg;
        hit_ok_next   = hit_ok_reg;
        best_next     = best_reg;
        next_id_next  = next_id_reg;
        removing_next = removing_reg;
        we            = 1'b0;
        wa            = wi_reg[IW-1:0];
        wd            = rd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ri_next       = '0;
                    wi_next       = '0;
                    hit_ok_next   = 1'b0;
                    removing_next = 1'b0;
                    state_next    = (count_reg == '0) ? S_WRITE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (cmd_reg) inside
                    CMD_REGISTER:
                    begin
                        if (!hit_ok_reg && rd_reg.ip == ip_reg)
                        begin
                            hit_ok_next = 1'b1;
                            hit_next    = ri_reg;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (removing_reg)
                        begin
                            we      = 1'b1;
                            wa      = wi_reg[IW-1:0];
                            wi_next = wi_reg + 1'b1;
                        end
                        else if (rd_reg.id == id_reg)
                        begin
                            removing_next = 1'b1;
                            hit_ok_next   = 1'b1;
                            wi_next       = ri_reg;
                        end
                    end
                    CMD_QUERY, CMD_DISCONNECT:
                    begin
                        if (!hit_ok_reg && rd_reg.id == id_reg)
                        begin
                            hit_ok_next = 1'b1;
                            hit_next    = ri_reg;
                        end
                    end
                    CMD_PICK:
                    begin
                        if (!hit_ok_reg || rd_reg.clients < best_reg)
                        begin
                            hit_ok_next = 1'b1;
                            hit_next    = ri_reg;
                            best_next   = rd_reg.clients;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (rd_reg.heartbeat != 8'd0)
                        begin
                            we           = 1'b1;
                            wa           = wi_reg[IW-1:0];
                            wd.heartbeat = rd_reg.heartbeat - 8'd1;
                            wi_next      = wi_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                ri_next    = ri_reg + 1'b1;
                state_next = (ri_reg + 1'b1 >= count_reg) ? S_WRITE : S_READ;
                if ((cmd_reg == CMD_QUERY || cmd_reg == CMD_DISCONNECT
                     || cmd_reg == CMD_REGISTER) && hit_ok_next)
                begin
                    state_next = S_WRITE;
                end
                if (cmd_reg > CMD_TICK)
                begin
                    state_next = S_WRITE;
                end
                if (state_next == S_WRITE)
                begin
                    ri_next = hit_next;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        if (!hit_ok_reg && count_reg < CW'(MAX_SERVERS))
                        begin
                            we           = 1'b1;
                            wa           = count_reg[IW-1:0];
                            wd.id        = next_id_reg;
                            wd.ip        = ip_reg;
                            wd.ports     = ports_reg;
                            wd.clients   = 16'd0;
                            wd.heartbeat = init_hb_reg;
                            count_next   = count_reg + 1'b1;
                            next_id_next = next_id_reg + 16'd1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_ok_reg)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_TICK:
                    begin
                        count_next = wi_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // In-place updates of the hit entry. rd_reg in S_DONE holds the hit entry,
    // as ri was pointed at it on leaving the scan.
    always_comb
    begin
        upd_we = 1'b0;
        upd_e  = rd_reg;
        if (state_reg == S_DONE && hit_ok_reg)
        begin
            case (cmd_reg)
                CMD_REGISTER:
                begin
                    upd_we = 1'b1;
                    if (rd_reg.heartbeat != 8'hFF)
                    begin
                        upd_e.heartbeat = rd_reg.heartbeat + 8'd1;
                    end
                end
                CMD_PICK:
                begin
                    upd_we = 1'b1;
                    if (rd_reg.clients != 16'hFFFF)
                    begin
                        upd_e.clients = rd_reg.clients + 16'd1;
                    end
                end
                CMD_DISCONNECT:
                begin
                    upd_we = 1'b1;
                    if (rd_reg.clients != 16'd0)
                    begin
                        upd_e.clients = rd_reg.clients - 16'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ri_reg       <= '0;
            wi_reg       <= '0;
            hit_reg      <= '0;
            hit_ok_reg   <= 1'b0;
            best_reg     <= '0;
            next_id_reg  <= '0;
            removing_reg <= 1'b0;
            init_hb_reg  <= HEARTBEAT_RESET;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ri_reg       <= ri_next;
            wi_reg       <= wi_next;
            hit_reg      <= hit_next;
            hit_ok_reg   <= hit_ok_next;
            best_reg     <= best_next;
            next_id_reg  <= next_id_next;
            removing_reg <= removing_next;
            out_v_reg    <= (state_reg == S_DONE);
            if (cfg_wr && paddr == 1'b0)
            begin
                init_hb_reg <= pwdata[7:0];
            end
        end
    end

    // Registered result fields.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && cmd_reg == CMD_REGISTER && !hit_ok_reg)
        begin
            out_e_reg.id      <= next_id_reg;
            out_e_reg.ip      <= ip_reg;
            out_e_reg.ports   <= ports_reg;
            out_e_reg.clients <= 16'd0;
        end
        if (state_reg == S_WRITE)
        begin
            out_f_reg  <= 1'b0;
            out_st_reg <= ST_OK;
            case (cmd_reg) inside
                CMD_REGISTER:
                begin
                    if (hit_ok_reg || count_reg < CW'(MAX_SERVERS))
                    begin
                        out_f_reg <= 1'b1;
                    end
                    else
                    begin
                        out_st_reg <= ST_FULL;
                    end
                end
                CMD_REMOVE, CMD_DISCONNECT:
                begin
                    if (!hit_ok_reg)
                    begin
                        out_st_reg <= ST_NOT_FOUND;
                    end
                end
                CMD_QUERY:
                begin
                    if (hit_ok_reg)
                    begin
                        out_f_reg <= 1'b1;
                    end
                    else
                    begin
                        out_st_reg <= ST_NOT_FOUND;
                    end
                end
                CMD_PICK:
                begin
                    if (hit_ok_reg)
                    begin
                        out_f_reg <= 1'b1;
                    end
                    else
                    begin
                        out_st_reg <= ST_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_DONE && hit_ok_reg)
        begin
            out_e_reg <= rd_reg;
        end
    end

    assign done             = out_v_reg;
    assign status           = out_st_reg;
    assign found            = out_f_reg;
    assign out_server_id    = out_f_reg ? out_e_reg.id : 16'd0;
    assign out_server_ip    = out_f_reg ? out_e_reg.ip : 32'd0;
    assign out_data_port    = out_f_reg ? out_e_reg.ports[47:32] : 16'd0;
    assign out_command_port = out_f_reg ? out_e_reg.ports[31:16] : 16'd0;
    assign out_retran_port  = out_f_reg ? out_e_reg.ports[15:0] : 16'd0;
    assign out_clients      = out_f_reg ? out_e_reg.clients : 16'd0;
    assign table_empty      = (count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SERVERS))
        else $error("entry count exceeds table size");

    a_done_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result beat while engine busy");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == ST_OK)
        else $error("found with error status");

endmodule

`default_nettype wire
